### design/mcc_pkg.sv
// Shared constants, command and status types for the minimum coin change block.
package mcc_pkg;

  localparam int MAX_DENOMS = 8;
  localparam int MAX_AMOUNT = 63;

  localparam int COIN_W = 6;
  localparam int AMT_W = 6;
  localparam int CELL_W = 7;
  localparam int ROW_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int CNT_W = $clog2(MAX_DENOMS + 1);
  localparam int TBL_AW = ROW_W + AMT_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;

  localparam logic [CELL_W-1:0] INF_MARK = 7'd127;

  typedef enum logic [1:0] {
    RD_FILL = 2'd0,
    RD_TOT  = 2'd1,
    RD_BT   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    fill_wr;
    logic    bt_init;
    logic    tot_latch;
    logic    take_step;
    logic    row_down;
    logic    emit_zero;
    logic    emit_none;
  } mcc_cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic no_path;
    logic last_amt;
    logic last_row;
    logic total_inf;
    logic take;
    logic bt_last;
    logic row_zero;
    logic k_zero;
    logic out_free;
  } mcc_sts_t;

endpackage

### design/mcc_ctrl.sv
// Controller state machine that sequences loading, table fill, backtrack and result output.
module mcc_ctrl
  import mcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_coin,
  output logic     in_ready,
  output mcc_cmd_t cmd,
  input  mcc_sts_t sts
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_START    = 10'b0000000010,
    S_FILL_RD  = 10'b0000000100,
    S_FILL_WR  = 10'b0000001000,
    S_TOT_RD   = 10'b0000010000,
    S_TOT_CHK  = 10'b0000100000,
    S_BT_RD    = 10'b0001000000,
    S_BT_CHK   = 10'b0010000000,
    S_FIN_ZERO = 10'b0100000000,
    S_FIN_NONE = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = RD_FILL;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_coin) begin
            cmd.start = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (sts.tgt_zero) begin
          state_next = S_FIN_ZERO;
        end else if (sts.no_path) begin
          state_next = S_FIN_NONE;
        end else begin
          state_next = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_FILL;
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        if (sts.last_amt && sts.last_row) begin
          state_next = S_TOT_RD;
        end else begin
          state_next = S_FILL_RD;
        end
      end
      S_TOT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_TOT;
        cmd.bt_init = 1'b1;
        state_next = S_TOT_CHK;
      end
      S_TOT_CHK: begin
        cmd.tot_latch = 1'b1;
        if (sts.total_inf) begin
          state_next = S_FIN_NONE;
        end else begin
          state_next = S_BT_RD;
        end
      end
      S_BT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_BT;
        state_next = S_BT_CHK;
      end
      S_BT_CHK: begin
        if (sts.take) begin
          if (sts.out_free) begin
            cmd.take_step = 1'b1;
            state_next = sts.bt_last ? S_IDLE : S_BT_RD;
          end
        end else if (sts.row_zero) begin
          state_next = sts.k_zero ? S_FIN_NONE : S_IDLE;
        end else begin
          cmd.row_down = 1'b1;
          state_next = S_BT_RD;
        end
      end
      S_FIN_ZERO: begin
        if (sts.out_free) begin
          cmd.emit_zero = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/mcc_dpath.sv
// Datapath with the denomination store, the minimum-count table memory and the output register.
module mcc_dpath
  import mcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [AMT_W-1:0]  cfg_data,
  input  logic [COIN_W-1:0] coin_value,
  input  mcc_cmd_t          cmd,
  output mcc_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COIN_W-1:0] chosen_coin,
  output logic [AMT_W-1:0]  coin_count,
  output logic              found,
  output logic              last_result
);

  logic [AMT_W-1:0]  target_amount;
  logic [COIN_W-1:0] coin_store [MAX_DENOMS];
  logic [CNT_W-1:0]  coins_loaded;
  logic [CNT_W-1:0]  n;
  logic [ROW_W-1:0]  ri;
  logic [AMT_W-1:0]  a;
  logic [AMT_W-1:0]  k;
  logic [CELL_W-1:0] total;
  logic [CELL_W-1:0] tbl [TBL_DEPTH];
  logic [CELL_W-1:0] rd_a;
  logic [CELL_W-1:0] rd_b;

  logic              store_ok;
  logic [CNT_W-1:0]  count_after;
  logic [CNT_W-1:0]  n_m1;
  logic [ROW_W-1:0]  ri_m1;
  logic [COIN_W-1:0] d;
  logic              amt_ge;
  logic [AMT_W-1:0]  diff;
  logic [CELL_W:0]   sum_b;
  logic [CELL_W-1:0] above;
  logic              use_prev;
  logic [CELL_W-1:0] best;
  logic [AMT_W-1:0]  k_inc;
  logic [TBL_AW-1:0] addr_a;
  logic [TBL_AW-1:0] addr_b;
  logic              out_free;
  logic              out_load;

  assign store_ok = (coin_value != '0) && (coins_loaded < CNT_W'(MAX_DENOMS));
  assign count_after = coins_loaded + CNT_W'(store_ok);
  assign n_m1 = n - 1'b1;
  assign ri_m1 = ri - 1'b1;
  assign d = coin_store[ri];
  assign amt_ge = (a >= d);
  assign diff = a - d;
  assign sum_b = {1'b0, rd_b} + 1'b1;
  assign above = (ri == '0) ? ((a == '0) ? '0 : INF_MARK) : rd_a;
  assign use_prev = amt_ge && (rd_b != INF_MARK) && (sum_b < {1'b0, above});
  assign best = use_prev ? sum_b[CELL_W-1:0] : above;
  assign k_inc = k + 1'b1;
  assign out_free = !out_valid || out_ready;
  assign out_load = cmd.take_step || cmd.emit_zero || cmd.emit_none;

  always_comb begin
    case (cmd.rd_sel)
      RD_FILL: addr_a = {ri_m1, a};
      RD_TOT:  addr_a = {n_m1[ROW_W-1:0], target_amount};
      RD_BT:   addr_a = {ri, a};
      default: addr_a = {ri, a};
    endcase
  end
  assign addr_b = {ri, diff};

  assign sts.tgt_zero = (target_amount == '0);
  assign sts.no_path = (target_amount > AMT_W'(MAX_AMOUNT)) || (n == '0);
  assign sts.last_amt = (a == target_amount);
  assign sts.last_row = ((CNT_W'(ri) + 1'b1) == n);
  assign sts.total_inf = (rd_a == INF_MARK);
  assign sts.take = amt_ge && (rd_b != INF_MARK) && (sum_b == {1'b0, rd_a});
  assign sts.bt_last = (diff == '0) || ({1'b0, k_inc} == total);
  assign sts.row_zero = (ri == '0);
  assign sts.k_zero = (k == '0);
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_amount <= '0;
      coins_loaded <= '0;
    end else begin
      if (cfg_we) begin
        target_amount <= cfg_data;
      end
      if (cmd.load) begin
        coins_loaded <= cmd.start ? '0 : count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      coin_store[coins_loaded[ROW_W-1:0]] <= coin_value;
    end
    if (cmd.start) begin
      n <= count_after;
      ri <= '0;
      a <= '0;
    end
    if (cmd.fill_wr) begin
      if (a == target_amount) begin
        a <= '0;
        ri <= ri + 1'b1;
      end else begin
        a <= a + 1'b1;
      end
    end
    if (cmd.bt_init) begin
      ri <= n_m1[ROW_W-1:0];
      a <= target_amount;
      k <= '0;
    end
    if (cmd.tot_latch) begin
      total <= rd_a;
    end
    if (cmd.take_step) begin
      a <= diff;
      k <= k_inc;
    end
    if (cmd.row_down) begin
      ri <= ri_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      tbl[{ri, a}] <= best;
    end
    if (cmd.rd_en) begin
      rd_a <= tbl[addr_a];
      rd_b <= tbl[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_step) begin
      chosen_coin <= d;
      coin_count <= total[AMT_W-1:0];
      found <= 1'b1;
      last_result <= sts.bt_last;
    end else if (cmd.emit_zero || cmd.emit_none) begin
      chosen_coin <= '0;
      coin_count <= '0;
      found <= cmd.emit_zero;
      last_result <= 1'b1;
    end
  end

endmodule

### design/min_coin_change_dp.sv
// Top level of the minimum coin change block: controller and datapath.
// Denominations arrive one per transaction and are taken one per cycle while the block is idle;
// a denomination of zero, or one beyond the store's capacity, is dropped. The transaction
// that carries last_coin starts a run: the table of minimum coin counts is filled one cell
// at a time, each by a registered read of the table memory and then a write, for n loaded
// denominations times target_amount + 1 cells. The backtrack then takes one step per chosen
// coin or per move to the previous denomination, each a table read and then a check, and
// each result waits for the output register to be free. A target of zero, or no loaded
// denominations, gives a single result.
module min_coin_change_dp
  import mcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [AMT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COIN_W-1:0] coin_value,
  input  logic              last_coin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COIN_W-1:0] chosen_coin,
  output logic [AMT_W-1:0]  coin_count,
  output logic              found,
  output logic              last_result
);

  mcc_cmd_t cmd;
  mcc_sts_t sts;

  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_coin (last_coin),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .coin_value  (coin_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chosen_coin (chosen_coin),
    .coin_count  (coin_count),
    .found       (found),
    .last_result (last_result)
  );

endmodule

### test/min_coin_change_dp_tb.sv
// Testbench for the minimum coin change block: directed table, random runs, predictor checks.
`timescale 1ns / 1ps

module min_coin_change_dp_tb
  import mcc_pkg::*;
();

  localparam int SETTLE = 8;
  localparam int WATCHDOG = 10000;
  localparam int ITEM_TOTAL = 170;
  localparam int CALM_FROM = 140;

  typedef struct packed {
    logic [COIN_W-1:0] coin;
    logic [AMT_W-1:0]  count;
    logic              found;
    logic              last;
  } change_t;

  typedef struct packed {
    logic [AMT_W-1:0]  tgt;
    logic [COIN_W-1:0] coin;
    logic              last;
    logic              typed;
    logic [COIN_W-1:0] e_coin;
    logic [AMT_W-1:0]  e_count;
    logic              e_found;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{6'd0,  6'd5,  1'b1, 1'b1, 6'd0, 6'd0, 1'b1},
    '{6'd63, 6'd0,  1'b1, 1'b1, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd1,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd0,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd63, 1'b1, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd2,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd4,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd8,  1'b1, 1'b1, 6'd0, 6'd0, 1'b0},
    '{6'd6,  6'd1,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd6,  6'd3,  1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd6,  6'd4,  1'b1, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd10, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd20, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd30, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd40, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd50, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd60, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd62, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd61, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd63, 6'd1,  1'b1, 1'b0, 6'd0, 6'd0, 1'b0},
    '{6'd1,  6'd1,  1'b1, 1'b1, 6'd1, 6'd1, 1'b1},
    '{6'd63, 6'd1,  1'b1, 1'b0, 6'd0, 6'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [AMT_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [COIN_W-1:0] coin_value = '0;
  logic              last_coin = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [COIN_W-1:0] chosen_coin;
  logic [AMT_W-1:0]  coin_count;
  logic              found;
  logic              last_result;

  change_t           coins_due[$];
  logic [COIN_W-1:0] denoms [MAX_DENOMS];
  int                n_denoms = 0;
  logic [AMT_W-1:0]  tgt_model = '0;
  logic [CELL_W-1:0] min_tbl [MAX_DENOMS][MAX_AMOUNT+1];
  bit                failed = 1'b0;
  bit                gap_on = 1'b1;
  bit                stall_on = 1'b1;
  int                items_sent = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  min_coin_change_dp dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coin_value (coin_value),
    .last_coin  (last_coin),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .chosen_coin(chosen_coin),
    .coin_count (coin_count),
    .found      (found),
    .last_result(last_result)
  );

  always #1 clk = ~clk;

  function automatic void step_coin(input logic [COIN_W-1:0] coin, input logic last,
                                    ref change_t res[$]);
    int n;
    int r;
    int a;
    int k;
    int d;
    int best;
    int total;
    change_t c;
    res.delete();
    if (coin != 0 && n_denoms < MAX_DENOMS) begin
      denoms[n_denoms] = coin;
      n_denoms++;
    end
    if (!last) return;
    n = n_denoms;
    n_denoms = 0;
    c.coin = '0;
    c.count = '0;
    c.found = 1'b0;
    c.last = 1'b1;
    if (tgt_model == 0) begin
      c.found = 1'b1;
      res.push_back(c);
      return;
    end
    for (r = 0; r < n; r++) begin
      d = int'(denoms[r]);
      for (a = 0; a <= int'(tgt_model); a++) begin
        if (r == 0) best = (a == 0) ? 0 : int'(INF_MARK);
        else best = int'(min_tbl[r-1][a]);
        if (a >= d && min_tbl[r][a-d] != INF_MARK && int'(min_tbl[r][a-d]) + 1 < best)
          best = int'(min_tbl[r][a-d]) + 1;
        min_tbl[r][a] = best[CELL_W-1:0];
      end
    end
    total = (n == 0) ? int'(INF_MARK) : int'(min_tbl[n-1][tgt_model]);
    if (total == int'(INF_MARK)) begin
      res.push_back(c);
      return;
    end
    r = n;
    a = int'(tgt_model);
    k = 0;
    while (a > 0 && r > 0 && k < total) begin
      d = int'(denoms[r-1]);
      if (a >= d && min_tbl[r-1][a-d] != INF_MARK &&
          int'(min_tbl[r-1][a-d]) + 1 == int'(min_tbl[r-1][a])) begin
        a -= d;
        k++;
        c.coin = d[COIN_W-1:0];
        c.count = total[AMT_W-1:0];
        c.found = 1'b1;
        c.last = (a == 0 || k == total);
        res.push_back(c);
      end else begin
        r--;
      end
    end
    if (k == 0) begin
      c.coin = '0;
      c.count = '0;
      c.found = 1'b0;
      c.last = 1'b1;
      res.push_back(c);
    end
  endfunction

  task automatic send_coin(input logic [COIN_W-1:0] coin, input logic last, input bit typed,
                           input change_t typed_res);
    change_t got[$];
    coin_value <= coin;
    last_coin <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    step_coin(coin, last, got);
    if (typed) begin
      got.delete();
      got.push_back(typed_res);
    end
    foreach (got[i]) coins_due.push_back(got[i]);
    items_sent++;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic set_target(input logic [AMT_W-1:0] value);
    in_valid <= 1'b0;
    while (coins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_model = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    change_t want;
    if (!rst && out_valid && out_ready) begin
      if (coins_due.size() == 0) begin
        $display("%0t: result with nothing expected: coin %0d count %0d found %0d last %0d",
                 $time, chosen_coin, coin_count, found, last_result);
        failed = 1'b1;
      end else begin
        want = coins_due.pop_front();
        if (chosen_coin !== want.coin) begin
          $display("%0t: chosen_coin expected %0d actual %0d", $time, want.coin, chosen_coin);
          failed = 1'b1;
        end
        if (coin_count !== want.count) begin
          $display("%0t: coin_count expected %0d actual %0d", $time, want.count, coin_count);
          failed = 1'b1;
        end
        if (found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, found);
          failed = 1'b1;
        end
        if (last_result !== want.last) begin
          $display("%0t: last_result expected %0d actual %0d", $time, want.last, last_result);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    change_t typed_res;
    int n_coins;
    logic [COIN_W-1:0] coin;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].tgt != tgt_model) set_target(DIRECTED[i].tgt);
      typed_res.coin = DIRECTED[i].e_coin;
      typed_res.count = DIRECTED[i].e_count;
      typed_res.found = DIRECTED[i].e_found;
      typed_res.last = 1'b1;
      send_coin(DIRECTED[i].coin, DIRECTED[i].last, DIRECTED[i].typed, typed_res);
    end

    while (items_sent < ITEM_TOTAL) begin
      if (items_sent >= CALM_FROM) begin
        gap_on = 1'b0;
        stall_on = 1'b0;
      end else begin
        gap_on = ($urandom_range(0, 2) != 0);
        stall_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: set_target('0);
          1: set_target(AMT_W'(MAX_AMOUNT));
          default: set_target(AMT_W'($urandom_range(1, 40)));
        endcase
      end
      n_coins = $urandom_range(0, 10);
      for (int j = 0; j <= n_coins; j++) begin
        if ($urandom_range(0, 11) == 0) coin = '0;
        else if ($urandom_range(0, 1) == 0) coin = COIN_W'($urandom_range(1, MAX_AMOUNT));
        else coin = COIN_W'($urandom_range(1, 12));
        send_coin(coin, j == n_coins, 1'b0, typed_res);
      end
    end

    in_valid <= 1'b0;
    while (coins_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed && coins_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/mcc_pkg.sv
design/mcc_ctrl.sv
design/mcc_dpath.sv
design/min_coin_change_dp.sv
test/min_coin_change_dp_tb.sv
